FILE: hw/rtl/lcdnb_pkg.sv
// Shared types, codes and helpers for the character LCD nibble bus controller.
`timescale 1ns / 1ps
`default_nettype none

package lcdnb_pkg;

	localparam int TIMER_WIDTH = 20;
	localparam int TICKS_WIDTH = 20;

	typedef logic [TIMER_WIDTH-1:0] tmr_t;
	typedef logic [TICKS_WIDTH-1:0] ticks_t;
	typedef logic [2:0]             cfg_idx_t;

	localparam cfg_idx_t REG_ENABLE_PULSE = 3'd0;
	localparam cfg_idx_t REG_NIBBLE_GAP   = 3'd1;
	localparam cfg_idx_t REG_READ_GAP     = 3'd2;
	localparam cfg_idx_t REG_SHORT_WAIT   = 3'd3;
	localparam cfg_idx_t REG_LONG_WAIT    = 3'd4;
	localparam cfg_idx_t REG_POLL_LIMIT   = 3'd5;

	localparam logic [2:0] CMD_INSTR_SHORT = 3'd0;
	localparam logic [2:0] CMD_INSTR_LONG  = 3'd1;
	localparam logic [2:0] CMD_DATA_WRITE  = 3'd2;
	localparam logic [2:0] CMD_SINGLE_NIB  = 3'd3;
	localparam logic [2:0] CMD_READ_DATA   = 3'd4;
	localparam logic [2:0] CMD_READ_ADDR   = 3'd5;
	localparam logic [2:0] CMD_WAIT_BUSY   = 3'd6;
	localparam logic [2:0] CMD_NONE        = 3'd7;

	localparam logic [7:0] ADDR_MASK = 8'h7F;

	localparam logic [15:0] RST_ENABLE_PULSE = 16'd13;
	localparam logic [15:0] RST_NIBBLE_GAP   = 16'd250;
	localparam logic [15:0] RST_READ_GAP     = 16'd2500;
	localparam ticks_t      RST_SHORT_WAIT   = 20'd2500;
	localparam ticks_t      RST_LONG_WAIT    = 20'd90000;
	localparam logic [7:0]  RST_POLL_LIMIT   = 8'd200;

	typedef struct packed {
		logic [15:0] enable_pulse;
		logic [15:0] nibble_gap;
		logic [15:0] read_gap;
		ticks_t      short_wait;
		ticks_t      long_wait;
		logic [7:0]  poll_limit;
	} cfg_t;

	typedef struct packed {
		logic       ready_res;
		logic       pin_enable;
		logic       pin_register_select;
		logic       pin_read_write;
		logic [3:0] pin_data_out;
		logic       pin_data_drive;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       busy_flag;
		logic       poll_timeout;
	} result_t;

	// Zero counts as one; counts beyond the timer's reach saturate.
	function automatic tmr_t load_value(ticks_t n);
		ticks_t      m;
		logic [32:0] wide;
		logic [32:0] tmax;
		m    = (n == '0) ? '0 : n - ticks_t'(1);
		wide = 33'(m);
		tmax = (33'd1 << TIMER_WIDTH) - 33'd1;
		if (wide > tmax) begin
			return '1;
		end
		return tmr_t'(wide);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lcdnb_cfg_regs.sv
// Configuration register file of the character LCD nibble bus controller.
`timescale 1ns / 1ps
`default_nettype none

module lcdnb_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire lcdnb_pkg::cfg_idx_t cfg_index,
	input  wire lcdnb_pkg::ticks_t   cfg_data,
	output lcdnb_pkg::cfg_t          cfg
);
	import lcdnb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_pulse <= RST_ENABLE_PULSE;
			cfg_q.nibble_gap   <= RST_NIBBLE_GAP;
			cfg_q.read_gap     <= RST_READ_GAP;
			cfg_q.short_wait   <= RST_SHORT_WAIT;
			cfg_q.long_wait    <= RST_LONG_WAIT;
			cfg_q.poll_limit   <= RST_POLL_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE_PULSE: cfg_q.enable_pulse <= cfg_data[15:0];
				REG_NIBBLE_GAP:   cfg_q.nibble_gap   <= cfg_data[15:0];
				REG_READ_GAP:     cfg_q.read_gap     <= cfg_data[15:0];
				REG_SHORT_WAIT:   cfg_q.short_wait   <= cfg_data;
				REG_LONG_WAIT:    cfg_q.long_wait    <= cfg_data;
				REG_POLL_LIMIT:   cfg_q.poll_limit   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdnb_seq.sv
// Pin timing sequencer: per-tick pin levels and phase/timer state update.
`timescale 1ns / 1ps
`default_nettype none

module lcdnb_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire lcdnb_pkg::cfg_t  cfg,
	input  wire logic             cmd_valid,
	input  wire logic [2:0]       cmd,
	input  wire logic [7:0]       cmd_byte,
	input  wire logic [3:0]       pin_data_in,
	output lcdnb_pkg::result_t    res
);
	import lcdnb_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_W_HI_EN, PH_W_GAP, PH_W_LO_EN, PH_SETTLE,
		PH_R_HI_EN, PH_R_HI_GAP, PH_R_LO_EN, PH_R_LO_GAP,
		PH_P_HI_EN, PH_P_HI_GAP, PH_P_LO_EN, PH_P_LO_GAP, PH_REPORT
	} phase_t;

	phase_t     phase_q, phase_d;
	tmr_t       timer_q, timer_d;
	logic [2:0] lcmd_q, lcmd_d;
	logic [7:0] lbyte_q, lbyte_d;
	logic [7:0] cap_q, cap_d;
	logic [7:0] polls_q, polls_d;
	logic       sel_q, sel_d;
	logic       dir_q, dir_d;

	logic [3:0] hi, lo;
	logic [7:0] limit;
	logic [7:0] polls_inc;
	ticks_t     pulse_ticks, gap_ticks, rgap_ticks;

	assign hi          = lbyte_q[7:4];
	assign lo          = lbyte_q[3:0];
	assign limit       = (cfg.poll_limit == '0) ? 8'd1 : cfg.poll_limit;
	assign polls_inc   = polls_q + 8'd1;
	assign pulse_ticks = ticks_t'(cfg.enable_pulse);
	assign gap_ticks   = ticks_t'(cfg.nibble_gap);
	assign rgap_ticks  = ticks_t'(cfg.read_gap);

	always_comb begin
		res                     = '0;
		res.pin_register_select = sel_q;
		res.pin_read_write      = dir_q;
		res.pin_data_drive      = ~dir_q;
		case (phase_q)
			PH_W_HI_EN: begin
				res.pin_enable     = 1'b1;
				res.pin_data_out   = hi;
				res.pin_data_drive = 1'b1;
			end
			PH_W_GAP: begin
				res.pin_data_out   = hi;
				res.pin_data_drive = 1'b1;
			end
			PH_W_LO_EN: begin
				res.pin_enable     = 1'b1;
				res.pin_data_out   = lo;
				res.pin_data_drive = 1'b1;
			end
			PH_SETTLE: begin
				res.pin_data_out   = (lcmd_q == CMD_SINGLE_NIB) ? hi : lo;
				res.pin_data_drive = 1'b1;
			end
			PH_R_HI_EN, PH_R_LO_EN: begin
				res.pin_enable     = 1'b1;
				res.pin_data_drive = 1'b0;
			end
			PH_R_HI_GAP, PH_R_LO_GAP: begin
				res.pin_data_drive = 1'b0;
			end
			PH_P_HI_EN, PH_P_LO_EN: begin
				res.pin_enable          = 1'b1;
				res.pin_register_select = 1'b0;
				res.pin_read_write      = 1'b1;
				res.pin_data_drive      = 1'b0;
			end
			PH_P_HI_GAP, PH_P_LO_GAP: begin
				res.pin_register_select = 1'b0;
				res.pin_read_write      = 1'b1;
				res.pin_data_drive      = 1'b0;
			end
			PH_REPORT: begin
				res.read_valid = 1'b1;
				if (lcmd_q == CMD_READ_DATA) begin
					res.read_byte = cap_q;
				end else if (lcmd_q == CMD_READ_ADDR) begin
					res.read_byte = cap_q & ADDR_MASK;
					res.busy_flag = cap_q[7];
				end else begin
					res.busy_flag    = cap_q[7];
					res.poll_timeout = cap_q[7];
				end
			end
			default: begin
				res.ready_res = 1'b1;
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		lcmd_d  = lcmd_q;
		lbyte_d = lbyte_q;
		cap_d   = cap_q;
		polls_d = polls_q;
		sel_d   = sel_q;
		dir_d   = dir_q;
		if (phase_q == PH_REPORT) begin
			phase_d = PH_IDLE;
			timer_d = '0;
		end else if (res.ready_res) begin
			phase_d = PH_IDLE;
			timer_d = '0;
			if (cmd_valid && cmd != CMD_NONE) begin
				lcmd_d  = cmd;
				lbyte_d = cmd_byte;
				cap_d   = '0;
				polls_d = '0;
				timer_d = load_value(pulse_ticks);
				if (cmd <= CMD_SINGLE_NIB) begin
					sel_d   = (cmd == CMD_DATA_WRITE);
					dir_d   = 1'b0;
					phase_d = PH_W_HI_EN;
				end else if (cmd <= CMD_READ_ADDR) begin
					sel_d   = (cmd == CMD_READ_DATA);
					dir_d   = 1'b1;
					phase_d = PH_R_HI_EN;
				end else begin
					phase_d = PH_P_HI_EN;
				end
			end
		end else if (timer_q != '0) begin
			timer_d = timer_q - tmr_t'(1);
		end else begin
			case (phase_q)
				PH_W_HI_EN: begin
					if (lcmd_q == CMD_SINGLE_NIB) begin
						phase_d = PH_SETTLE;
						timer_d = load_value(cfg.short_wait);
					end else begin
						phase_d = PH_W_GAP;
						timer_d = load_value(gap_ticks);
					end
				end
				PH_W_GAP: begin
					phase_d = PH_W_LO_EN;
					timer_d = load_value(pulse_ticks);
				end
				PH_W_LO_EN: begin
					phase_d = PH_SETTLE;
					timer_d = load_value((lcmd_q == CMD_INSTR_LONG) ? cfg.long_wait
						: cfg.short_wait);
				end
				PH_SETTLE: begin
					phase_d = PH_IDLE;
				end
				PH_R_HI_EN: begin
					cap_d   = {pin_data_in, cap_q[3:0]};
					phase_d = PH_R_HI_GAP;
					timer_d = load_value(rgap_ticks);
				end
				PH_R_HI_GAP: begin
					phase_d = PH_R_LO_EN;
					timer_d = load_value(pulse_ticks);
				end
				PH_R_LO_EN: begin
					cap_d   = {cap_q[7:4], pin_data_in};
					phase_d = PH_R_LO_GAP;
					timer_d = load_value(rgap_ticks);
				end
				PH_R_LO_GAP: begin
					phase_d = PH_REPORT;
				end
				PH_P_HI_EN: begin
					cap_d   = {pin_data_in[3], 7'd0};
					phase_d = PH_P_HI_GAP;
					timer_d = load_value(gap_ticks);
				end
				PH_P_HI_GAP: begin
					phase_d = PH_P_LO_EN;
					timer_d = load_value(pulse_ticks);
				end
				PH_P_LO_EN: begin
					phase_d = PH_P_LO_GAP;
					timer_d = load_value(gap_ticks);
				end
				default: begin
					if (!cap_q[7]) begin
						phase_d = PH_REPORT;
					end else begin
						polls_d = polls_inc;
						if (polls_inc >= limit || polls_inc == '0) begin
							phase_d = PH_REPORT;
						end else begin
							phase_d = PH_P_HI_EN;
							timer_d = load_value(pulse_ticks);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			lcmd_q  <= '0;
			lbyte_q <= '0;
			cap_q   <= '0;
			polls_q <= '0;
			sel_q   <= 1'b0;
			dir_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			lcmd_q  <= lcmd_d;
			lbyte_q <= lbyte_d;
			cap_q   <= cap_d;
			polls_q <= polls_d;
			sel_q   <= sel_d;
			dir_q   <= dir_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_bus_controller.sv
// Top level of the character LCD 4-bit bus controller with its result register.
// Usage:
//   Input channel (in_valid / in_stall): one transaction per clock tick of the
//   LCD timing base, carrying cmd_valid, cmd, cmd_byte and the sampled D7..D4
//   pins. Every input transaction yields exactly one result transaction.
//   Output channel (out_valid / out_stall): pin levels for that tick plus
//   ready_res and the read/poll report fields.
//   Configuration channel (cfg_valid / cfg_ready): register index and data;
//   cfg_ready is always high. Write only while the sequencer is idle.
// Timing: the result is registered and appears in the cycle after its input transaction.
// Throughput: one transaction per cycle unless in_stall; the sequencer state
//   and the result register both advance on every accepted input transaction.
// Reset: arst_n clears the sequencer to idle and the result register to empty;
//   configuration registers return to their defaults.
// Stall: while a result waits and out_stall is high, in_stall is raised and
//   the sequencer holds; the result register is freed in the cycle it is taken.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_bus_controller (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                cmd_valid,
	input  wire logic [2:0]          cmd,
	input  wire logic [7:0]          cmd_byte,
	input  wire logic [3:0]          pin_data_in,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     ready_res,
	output logic                     pin_enable,
	output logic                     pin_register_select,
	output logic                     pin_read_write,
	output logic [3:0]               pin_data_out,
	output logic                     pin_data_drive,
	output logic                     read_valid,
	output logic [7:0]               read_byte,
	output logic                     busy_flag,
	output logic                     poll_timeout,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire lcdnb_pkg::cfg_idx_t cfg_index,
	input  wire lcdnb_pkg::ticks_t   cfg_data
);
	import lcdnb_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    step;

	assign in_stall = out_valid_q && out_stall;
	assign step     = in_valid && !in_stall;

	lcdnb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcdnb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cfg         (cfg),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_byte    (cmd_byte),
		.pin_data_in (pin_data_in),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign ready_res           = res_q.ready_res;
	assign pin_enable          = res_q.pin_enable;
	assign pin_register_select = res_q.pin_register_select;
	assign pin_read_write      = res_q.pin_read_write;
	assign pin_data_out        = res_q.pin_data_out;
	assign pin_data_drive      = res_q.pin_data_drive;
	assign read_valid          = res_q.read_valid;
	assign read_byte           = res_q.read_byte;
	assign busy_flag           = res_q.busy_flag;
	assign poll_timeout        = res_q.poll_timeout;

`ifndef SYNTHESIS
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_drive_vs_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pin_data_drive != pin_read_write))
		else $error("data drive conflicts with read/write level");

	a_report_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_valid) |-> (!pin_enable && !ready_res))
		else $error("report tick with enable or ready");

	a_idle_no_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ready_res) |-> (!pin_enable && pin_data_out == 4'd0))
		else $error("idle tick drives enable or data");
`endif

endmodule

`default_nettype wire
